// ===== rtl/core/u16u8_pkg.sv =====
// Shared widths and constants for the UTF-16 to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

   localparam int UNIT_WIDTH  = 16;
   localparam int BYTE_WIDTH  = 8;
   localparam int MAX_BYTES   = 4;
   localparam int COUNT_WIDTH = $clog2(MAX_BYTES + 1);
   localparam int SURR_WIDTH  = 10;
   localparam int CP_WIDTH    = 21;

   typedef logic [UNIT_WIDTH-1:0]  unit_type;
   typedef logic [BYTE_WIDTH-1:0]  byte_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [SURR_WIDTH-1:0]  surr_type;
   typedef logic [CP_WIDTH-1:0]    cp_type;

   localparam unit_type BOM_UNIT      = 16'hFEFF;
   localparam unit_type ONE_BYTE_MAX  = 16'h007F;
   localparam unit_type TWO_BYTE_MAX  = 16'h07FF;
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam cp_type   SUPP_BASE     = 21'h10000;
   localparam byte_type LEAD_TWO      = 8'hC0;
   localparam byte_type LEAD_THREE    = 8'hE0;
   localparam byte_type LEAD_FOUR     = 8'hF0;
   localparam byte_type CONT_MARK     = 8'h80;

endpackage

`default_nettype wire

// ===== rtl/core/u16u8_if.sv =====
// Request and response channel interfaces for the transcoder.
`default_nettype none

interface u16u8_req_if import u16u8_pkg::*; ();
   logic     valid;
   logic     ready;
   unit_type code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16u8_rsp_if import u16u8_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/utf16_to_utf8_transcoder_unit.sv =====
// The first UTF-8 byte of a request is presented the cycle after the request is accepted.
// Throughput: one byte per cycle out while rsp_ch.ready is high; a request yields 1 to 4 bytes,
// or none (a dropped mark or a held high surrogate).
// A new request is taken in the cycle the last buffered byte leaves.
// Reset (synchronous) empties the buffer, clears any held surrogate and swap_ff.
`default_nettype none

module utf16_to_utf8_transcoder_unit import u16u8_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   u16u8_req_if.sink        req_ch,
   u16u8_rsp_if.source      rsp_ch
);

   logic      swap_ff;
   logic      pend_ff, pend_in;
   surr_type  surr_ff, surr_in;
   count_type cnt_ff, cnt_in;
   byte_type  buf_ff [MAX_BYTES];
   byte_type  buf_in [MAX_BYTES];

   unit_type  raw;
   unit_type  unit;
   cp_type    cp;
   count_type dec_cnt;
   byte_type  dec_buf [MAX_BYTES];
   logic      dec_pend;
   surr_type  dec_surr;
   logic      accept;
   logic      pop;

   assign rsp_ch.valid     = (cnt_ff != '0);
   assign rsp_ch.out_byte  = buf_ff[0];
   assign rsp_ch.last_byte = (cnt_ff == count_type'(1));
   assign pop              = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready     = (cnt_ff == '0) || ((cnt_ff == count_type'(1)) && rsp_ch.ready);
   assign accept           = req_ch.valid && req_ch.ready;

   // decode one request into up to four bytes
   always_comb begin
      raw  = req_ch.code_unit;
      unit = swap_ff ? {raw[7:0], raw[15:8]} : raw;
      cp   = {1'b0, surr_ff, unit[SURR_WIDTH-1:0]} + SUPP_BASE;
      dec_cnt  = '0;
      dec_pend = pend_ff;
      dec_surr = surr_ff;
      for (int i = 0; i < MAX_BYTES; i++) begin
         dec_buf[i] = '0;
      end
      priority if (raw == '0) begin
         dec_cnt  = count_type'(1);
         dec_pend = 1'b0;
         dec_surr = '0;
      end else if (pend_ff) begin
         dec_cnt    = count_type'(4);
         dec_buf[0] = LEAD_FOUR | {5'b0, cp[20:18]};
         dec_buf[1] = CONT_MARK | {2'b0, cp[17:12]};
         dec_buf[2] = CONT_MARK | {2'b0, cp[11:6]};
         dec_buf[3] = CONT_MARK | {2'b0, cp[5:0]};
         dec_pend   = 1'b0;
         dec_surr   = '0;
      end else if (raw == BOM_UNIT) begin
         dec_cnt = '0;
      end else if (unit[15:10] == HIGH_SURR_TAG) begin
         dec_pend = 1'b1;
         dec_surr = unit[SURR_WIDTH-1:0];
      end else if (unit <= ONE_BYTE_MAX) begin
         dec_cnt    = count_type'(1);
         dec_buf[0] = unit[7:0];
      end else if (unit <= TWO_BYTE_MAX) begin
         dec_cnt    = count_type'(2);
         dec_buf[0] = LEAD_TWO | {3'b0, unit[10:6]};
         dec_buf[1] = CONT_MARK | {2'b0, unit[5:0]};
      end else begin
         dec_cnt    = count_type'(3);
         dec_buf[0] = LEAD_THREE | {4'b0, unit[15:12]};
         dec_buf[1] = CONT_MARK | {2'b0, unit[11:6]};
         dec_buf[2] = CONT_MARK | {2'b0, unit[5:0]};
      end
   end

   always_comb begin
      pend_in = pend_ff;
      surr_in = surr_ff;
      cnt_in  = cnt_ff;
      for (int i = 0; i < MAX_BYTES; i++) begin
         buf_in[i] = buf_ff[i];
      end
      priority if (accept) begin
         pend_in = dec_pend;
         surr_in = dec_surr;
         cnt_in  = dec_cnt;
         for (int i = 0; i < MAX_BYTES; i++) begin
            buf_in[i] = dec_buf[i];
         end
      end else if (pop) begin
         cnt_in = cnt_ff - count_type'(1);
         for (int i = 0; i < MAX_BYTES - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_in[MAX_BYTES-1] = '0;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b0;
         pend_ff <= 1'b0;
         surr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            swap_ff <= csr_write_data;
         end
         pend_ff <= pend_in;
         surr_ff <= surr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

endmodule

`default_nettype wire

// ===== verif/utf16_to_utf8_transcoder_unit_tb.sv =====
// Self-checking regression for the UTF-16 to UTF-8 transcoder: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder_unit_tb;
   import u16u8_pkg::*;

   typedef struct packed {
      byte_type data;
      logic     last;
   } utf8_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   u16u8_req_if req_bus ();
   u16u8_rsp_if rsp_bus ();

   utf16_to_utf8_transcoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_bus.sink),
      .rsp_ch           (rsp_bus.source)
   );

   // transcoder state as seen by the testbench
   bit            swap_mode;
   bit            surrogate_held;
   surr_type      held_bits;
   utf8_byte_type expected_bytes[$];
   utf8_byte_type oldest_byte;

   int unsigned mismatches;
   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;

   always #1 clock = ~clock;

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic unit_type swap_bytes(input unit_type u);
      return {u[7:0], u[15:8]};
   endfunction

   task automatic push_byte(input byte_type b, input logic last);
      utf8_byte_type e;
      e.data = b;
      e.last = last;
      expected_bytes.push_back(e);
   endtask

   task automatic predict_bytes(input unit_type raw);
      unit_type c;
      cp_type   cp;
      if (raw == '0) begin
         surrogate_held = 1'b0;
         held_bits      = '0;
         push_byte(8'h00, 1'b1);
         return;
      end
      c = swap_mode ? swap_bytes(raw) : raw;
      if (surrogate_held) begin
         cp = {1'b0, held_bits, c[9:0]} + SUPP_BASE;
         surrogate_held = 1'b0;
         held_bits      = '0;
         push_byte(LEAD_FOUR | {5'b0, cp[20:18]}, 1'b0);
         push_byte(CONT_MARK | {2'b0, cp[17:12]}, 1'b0);
         push_byte(CONT_MARK | {2'b0, cp[11:6]}, 1'b0);
         push_byte(CONT_MARK | {2'b0, cp[5:0]}, 1'b1);
         return;
      end
      if (raw == BOM_UNIT) return;
      if (c[15:10] == HIGH_SURR_TAG) begin
         surrogate_held = 1'b1;
         held_bits      = c[9:0];
         return;
      end
      if (c <= ONE_BYTE_MAX) begin
         push_byte(c[7:0], 1'b1);
      end else if (c <= TWO_BYTE_MAX) begin
         push_byte(LEAD_TWO | {3'b0, c[10:6]}, 1'b0);
         push_byte(CONT_MARK | {2'b0, c[5:0]}, 1'b1);
      end else begin
         push_byte(LEAD_THREE | {4'b0, c[15:12]}, 1'b0);
         push_byte(CONT_MARK | {2'b0, c[11:6]}, 1'b0);
         push_byte(CONT_MARK | {2'b0, c[5:0]}, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %h last %b", rsp_bus.out_byte, rsp_bus.last_byte);
         end else begin
            oldest_byte = expected_bytes.pop_front();
            if (rsp_bus.out_byte !== oldest_byte.data ||
                rsp_bus.last_byte !== oldest_byte.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("byte mismatch: expected %h last %b, got %h last %b",
                           oldest_byte.data, oldest_byte.last,
                           rsp_bus.out_byte, rsp_bus.last_byte);
            end
         end
      end
   end

   // one request; valid stays high into the next request unless an idle cycle is drawn
   task automatic send_unit(input unit_type u);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.code_unit <= unit_type'($urandom);
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.code_unit <= u;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_bytes(u);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_swap(input bit v);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'($urandom_range(1));
      swap_mode = v;
   endtask

   // sends a unit given in decoded form, swapped on the wire when needed
   task automatic send_decoded(input unit_type u);
      send_unit(swap_mode ? swap_bytes(u) : u);
   endtask

   task automatic send_random_items(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_decoded(unit_type'($urandom_range(16'h0001, 16'h007F)));
         end else if (pick < 25) begin
            send_decoded(unit_type'($urandom_range(16'h0080, 16'h07FF)));
         end else if (pick < 45) begin
            send_decoded(unit_type'($urandom_range(16'h0800, 16'hFFFF)));
         end else if (pick < 75) begin
            send_decoded(unit_type'($urandom_range(16'hD800, 16'hDBFF)));
            if ($urandom_range(99) < 80)
               send_decoded(unit_type'($urandom_range(16'hDC00, 16'hDFFF)));
            else
               send_unit(unit_type'($urandom));
         end else if (pick < 80) begin
            send_unit(BOM_UNIT);
         end else if (pick < 83) begin
            send_unit(16'hFFFE);
         end else if (pick < 88) begin
            send_unit('0);
         end else begin
            send_unit(unit_type'($urandom));
         end
      end
   endtask

   task automatic test_plain_extremes();
      set_swap(1'b0);
      send_unit(16'h0000);
      send_unit(16'h0001);
      send_unit(16'h007F);
      send_unit(16'h0080);
      send_unit(16'h07FF);
      send_unit(16'h0800);
      send_unit(16'hFFFF);
      send_unit(16'hFFFE);
      send_unit(BOM_UNIT);
      send_unit(16'hDC00);
      send_unit(16'hDFFF);
   endtask

   task automatic test_plain_surrogates();
      send_unit(16'hD800);
      send_unit(16'hDC00);
      send_unit(16'hDBFF);
      send_unit(16'hDFFF);
      send_unit(16'hD800);
      send_unit(BOM_UNIT);
      send_unit(16'hDA55);
      send_unit(16'hD9AA);
      send_unit(16'hD800);
      send_unit(16'h0000);
      send_unit(16'h0041);
   endtask

   task automatic test_swapped_units();
      set_swap(1'b1);
      send_unit(16'hFFFE);
      send_unit(BOM_UNIT);
      send_unit(16'h0100);
      send_unit(16'h4100);
      send_unit(16'h00D8);
      send_unit(16'h00DC);
      send_unit(16'hFFDB);
      send_unit(16'hFFDF);
      send_unit(16'h0000);
   endtask

   // halves of one pair decoded under different byte orders
   task automatic test_swap_mid_pair();
      send_unit(16'h00D8);
      set_swap(1'b0);
      send_unit(16'hDC00);
      send_unit(16'hDBFF);
      set_swap(1'b1);
      send_unit(16'hFFDF);
   endtask

   task automatic test_random_phases();
      req_idle_pct  = 37;
      rsp_stall_pct = 37;
      for (int phase = 0; phase < 4; phase++) begin
         set_swap(phase == 0 ? 1'b0 : (phase == 1 ? 1'b1 : bit'($urandom_range(1))));
         send_random_items(40);
      end
   endtask

   task automatic test_random_unbroken();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_swap(bit'($urandom_range(1)));
      send_random_items(30);
      req_idle_pct  = 37;
      rsp_stall_pct = 37;
   endtask

   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.code_unit = '0;
      swap_mode      = 1'b0;
      surrogate_held = 1'b0;
      held_bits      = '0;
      mismatches     = 0;
      req_idle_pct   = 37;
      rsp_stall_pct  = 37;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_extremes();
      test_plain_surrogates();
      test_swapped_units();
      test_swap_mid_pair();
      test_random_phases();
      test_random_unbroken();

      drain_responses();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("utf16_to_utf8_transcoder_unit regression: pass");
      end else begin
         $display("utf16_to_utf8_transcoder_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("utf16_to_utf8_transcoder_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_if.sv
rtl/core/utf16_to_utf8_transcoder_unit.sv
verif/utf16_to_utf8_transcoder_unit_tb.sv
